[rtl/crt_pkg.sv]
// Shared constants and codes for the command retry tracker.
package crt_pkg;

    localparam int SEQ_BITS = 6;
    localparam int SLOTS    = 1 << SEQ_BITS;

    localparam int TIME_W   = 64;
    localparam int ID_W     = 8;
    localparam int RTR_W    = 4;
    localparam int CNT_W    = 32;
    localparam int SLOT_W   = ID_W + TIME_W + RTR_W;

    localparam logic [ID_W-1:0] MSG_TIME_SYNC   = 8'h05;
    localparam logic [ID_W-1:0] MSG_TIME_ADJUST = 8'h06;
    localparam logic [7:0]      STATUS_OK       = 8'h00;
    localparam logic [7:0]      TIMES_LENGTH    = 8'd26;
    localparam logic [7:0]      MIN_LENGTH      = 8'd2;

    localparam logic [31:0]      TIMEOUT_RESET = 32'd200000;
    localparam logic [RTR_W-1:0] LIMIT_RESET   = 4'd3;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_LIMIT   = 1'b1;

    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_RESP = 2'd2;

    localparam logic [1:0] KIND_SENT   = 2'd0;
    localparam logic [1:0] KIND_RESENT = 2'd1;
    localparam logic [1:0] KIND_DROP   = 2'd2;
    localparam logic [1:0] KIND_ACK    = 2'd3;

endpackage

[rtl/crt_ram.sv]
// Generic single-port-write, registered-read RAM.
module crt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write, then register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/crt_alu.sv]
// Shared 64-bit add/subtract unit with carry out (carry set means a >= b on subtract).
module crt_alu (
    input  logic [crt_pkg::TIME_W-1:0] i_a,
    input  logic [crt_pkg::TIME_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [crt_pkg::TIME_W-1:0] o_sum,
    output logic                       o_carry
);

    logic [crt_pkg::TIME_W-1:0] b_eff;

    // add a to b or to its complement
    assign b_eff = i_sub ? ~i_b : i_b;
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, b_eff}
                              + {{crt_pkg::TIME_W{1'b0}}, i_sub};

endmodule

[rtl/command_retry_tracker_core.sv]
// Top level: sequencer over the slot table and the shared adder.
//
// Channel   Direction  Handshake                 Payload
// command   in         i_start & !o_busy          i_action .. i_t3_us
// result    out        o_valid (one cycle)        o_kind .. o_last
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Busy: send in S_SEND; response in S_RD, S_RSP_EV (adjust: S_D1-S_NEG, S_SEND).
// A tick walks all 64 slots: S_RD, S_TICK_EV, S_TICK_WR on resend; then S_FLUSH.
// Results are registered; a tick result waits for the next due slot or S_FLUSH.
// All steps run through one 64-bit adder and one table read port.
// Reset is synchronous; it clears valid bits, counters and the sequencer.
// Results go out as one-cycle strobes; the receiver cannot stall them.
module command_retry_tracker_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [1:0]                   i_action,
    input  logic [63:0]                  i_now_us,
    input  logic [7:0]                   i_msgid,
    input  logic [crt_pkg::SEQ_BITS-1:0] i_seq,
    input  logic [7:0]                   i_status,
    input  logic [7:0]                   i_data_length,
    input  logic [63:0]                  i_t1_us,
    input  logic [63:0]                  i_t2_us,
    input  logic [63:0]                  i_t3_us,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [31:0]                  i_cfg_data,
    output logic                         o_valid,
    output logic [1:0]                   o_kind,
    output logic [crt_pkg::SEQ_BITS-1:0] o_out_seq,
    output logic [7:0]                   o_out_msgid,
    output logic [7:0]                   o_out_status,
    output logic signed [63:0]           o_adjust_offset_us,
    output logic [31:0]                  o_timeout_total,
    output logic [31:0]                  o_resend_total,
    output logic                         o_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_TICK_EV, S_TICK_WR, S_FLUSH, S_RSP_EV,
        S_D1, S_D2, S_SUM, S_ABS, S_NEG, S_SEND
    } t_state;

    localparam int SB = crt_pkg::SEQ_BITS;
    localparam int TW = crt_pkg::TIME_W;

    t_state r_state;
    logic [1:0]                 r_act;
    logic [TW-1:0]              r_now, r_t1, r_t2, r_t3, r_acc, r_tmp, r_adj;
    logic [crt_pkg::ID_W-1:0]   r_msgid;
    logic [7:0]                 r_status, r_len;
    logic [SB-1:0]              r_idx, r_nseq;
    logic [31:0]                r_timeout;
    logic [crt_pkg::RTR_W-1:0]  r_limit;
    logic [crt_pkg::CNT_W-1:0]  r_tcnt, r_rcnt;
    logic [crt_pkg::SLOTS-1:0]  r_valid;

    // held tick result, sent once the next one (or the walk end) is known
    logic                       r_hv;
    logic [1:0]                 r_hkind;
    logic [SB-1:0]              r_hseq;
    logic [crt_pkg::ID_W-1:0]   r_hmsgid;
    logic [crt_pkg::CNT_W-1:0]  r_htc, r_hrc;

    logic [crt_pkg::SLOT_W-1:0] rd_data, wr_data;
    logic [crt_pkg::ID_W-1:0]   rd_msgid;
    logic [TW-1:0]              rd_deadline;
    logic [crt_pkg::RTR_W-1:0]  rd_retries;
    logic                       wr_en;
    logic [SB-1:0]              wr_addr;

    logic [TW-1:0] alu_a, alu_b, alu_sum;
    logic          alu_sub, alu_carry;

    logic due, drop, send_adjust;
    logic [crt_pkg::CNT_W-1:0] tc_next, rc_next;

    assign o_busy = (r_state != S_IDLE);
    assign {rd_msgid, rd_deadline, rd_retries} = rd_data;

    // select adder operands per step
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_SEND, S_TICK_WR: begin
                alu_a = r_now;
                alu_b = {{(TW-32){1'b0}}, r_timeout};
            end
            S_TICK_EV: begin
                alu_a = r_now; alu_b = rd_deadline; alu_sub = 1'b1;
            end
            S_D1: begin
                alu_a = r_t2; alu_b = r_t1; alu_sub = 1'b1;
            end
            S_D2: begin
                alu_a = r_t3; alu_b = r_now; alu_sub = 1'b1;
            end
            S_SUM: begin
                alu_a = r_acc; alu_b = r_tmp;
            end
            S_ABS: begin
                alu_b = r_acc; alu_sub = 1'b1;
            end
            S_NEG: begin
                alu_b = {1'b0, r_tmp[TW-1:1]}; alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // table write: new command on send, renewed deadline on resend
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = {rd_msgid, alu_sum, rd_retries + 4'd1};
        if (r_state == S_SEND) begin
            wr_en   = 1'b1;
            wr_addr = r_nseq;
            wr_data = {r_msgid, alu_sum, {crt_pkg::RTR_W{1'b0}}};
        end else if (r_state == S_TICK_WR) begin
            wr_en = 1'b1;
        end
    end

    assign due         = r_valid[r_idx] & alu_carry;
    assign drop        = (rd_retries >= r_limit);
    assign tc_next     = r_tcnt + {{(crt_pkg::CNT_W-1){1'b0}}, drop};
    assign rc_next     = r_rcnt + {{(crt_pkg::CNT_W-1){1'b0}}, ~drop};
    assign send_adjust = (r_status == crt_pkg::STATUS_OK)
                         && (r_msgid == crt_pkg::MSG_TIME_SYNC)
                         && (r_len >= crt_pkg::TIMES_LENGTH);

    crt_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    crt_ram #(
        .WIDTH (crt_pkg::SLOT_W),
        .DEPTH (crt_pkg::SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    // sequencer, table state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_nseq    <= '0;
            r_tcnt    <= '0;
            r_rcnt    <= '0;
            r_hv      <= 1'b0;
            r_timeout <= crt_pkg::TIMEOUT_RESET;
            r_limit   <= crt_pkg::LIMIT_RESET;
            o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == crt_pkg::CFG_TIMEOUT) begin
                    r_timeout <= i_cfg_data;
                end else begin
                    r_limit <= i_cfg_data[crt_pkg::RTR_W-1:0];
                end
            end
            case (r_state)
                S_IDLE: begin
                    o_valid <= 1'b0;
                    if (i_start) begin
                        r_act    <= i_action;
                        r_now    <= i_now_us;
                        r_msgid  <= i_msgid;
                        r_status <= i_status;
                        r_len    <= i_data_length;
                        r_t1     <= i_t1_us;
                        r_t2     <= i_t2_us;
                        r_t3     <= i_t3_us;
                        r_adj    <= '0;
                        if (i_action == crt_pkg::ACT_SEND) begin
                            r_state <= S_SEND;
                        end else if (i_action == crt_pkg::ACT_TICK) begin
                            r_idx   <= '0;
                            r_state <= S_RD;
                        end else if (i_action == crt_pkg::ACT_RESP
                                     && i_data_length >= crt_pkg::MIN_LENGTH) begin
                            r_idx   <= i_seq;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    o_valid <= 1'b0;
                    r_state <= (r_act == crt_pkg::ACT_TICK) ? S_TICK_EV : S_RSP_EV;
                end
                S_TICK_EV: begin
                    o_valid <= due && r_hv;
                    if (due) begin
                        if (r_hv) begin
                            o_kind             <= r_hkind;
                            o_out_seq          <= r_hseq;
                            o_out_msgid        <= r_hmsgid;
                            o_out_status       <= '0;
                            o_adjust_offset_us <= '0;
                            o_timeout_total    <= r_htc;
                            o_resend_total     <= r_hrc;
                            o_last             <= 1'b0;
                        end
                        r_hv     <= 1'b1;
                        r_hkind  <= drop ? crt_pkg::KIND_DROP : crt_pkg::KIND_RESENT;
                        r_hseq   <= r_idx;
                        r_hmsgid <= rd_msgid;
                        r_htc    <= tc_next;
                        r_hrc    <= rc_next;
                        r_tcnt   <= tc_next;
                        r_rcnt   <= rc_next;
                    end
                    if (due && !drop) begin
                        r_state <= S_TICK_WR;
                    end else begin
                        if (due) begin
                            r_valid[r_idx] <= 1'b0;
                        end
                        r_idx   <= r_idx + SB'(1);
                        r_state <= (r_idx == {SB{1'b1}}) ? S_FLUSH : S_RD;
                    end
                end
                S_TICK_WR: begin
                    o_valid <= 1'b0;
                    r_idx   <= r_idx + SB'(1);
                    r_state <= (r_idx == {SB{1'b1}}) ? S_FLUSH : S_RD;
                end
                S_FLUSH: begin
                    o_valid <= r_hv;
                    if (r_hv) begin
                        o_kind             <= r_hkind;
                        o_out_seq          <= r_hseq;
                        o_out_msgid        <= r_hmsgid;
                        o_out_status       <= '0;
                        o_adjust_offset_us <= '0;
                        o_timeout_total    <= r_htc;
                        o_resend_total     <= r_hrc;
                        o_last             <= 1'b1;
                    end
                    r_hv    <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_RSP_EV: begin
                    if (r_valid[r_idx] && rd_msgid == r_msgid) begin
                        r_valid[r_idx]     <= 1'b0;
                        o_valid            <= 1'b1;
                        o_kind             <= crt_pkg::KIND_ACK;
                        o_out_seq          <= r_idx;
                        o_out_msgid        <= r_msgid;
                        o_out_status       <= r_status;
                        o_adjust_offset_us <= '0;
                        o_timeout_total    <= r_tcnt;
                        o_resend_total     <= r_rcnt;
                        o_last             <= ~send_adjust;
                        r_state            <= send_adjust ? S_D1 : S_IDLE;
                    end else begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_D1: begin
                    o_valid <= 1'b0;
                    r_acc   <= alu_sum;
                    r_state <= S_D2;
                end
                S_D2: begin
                    o_valid <= 1'b0;
                    r_tmp   <= alu_sum;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    o_valid <= 1'b0;
                    r_acc   <= alu_sum;
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    // magnitude of the sum
                    o_valid <= 1'b0;
                    r_tmp   <= r_acc[TW-1] ? alu_sum : r_acc;
                    r_state <= S_NEG;
                end
                S_NEG: begin
                    // negated, truncated half of the sum
                    o_valid <= 1'b0;
                    r_adj   <= r_acc[TW-1] ? {1'b0, r_tmp[TW-1:1]} : alu_sum;
                    r_msgid <= crt_pkg::MSG_TIME_ADJUST;
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    r_valid[r_nseq]    <= 1'b1;
                    r_nseq             <= r_nseq + SB'(1);
                    o_valid            <= 1'b1;
                    o_kind             <= crt_pkg::KIND_SENT;
                    o_out_seq          <= r_nseq;
                    o_out_msgid        <= r_msgid;
                    o_out_status       <= '0;
                    o_adjust_offset_us <= r_adj;
                    o_timeout_total    <= r_tcnt;
                    o_resend_total     <= r_rcnt;
                    o_last             <= 1'b1;
                    r_state            <= S_IDLE;
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // no held tick result survives outside a walk
    a_held_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hv)
        else $error("held result outside tick walk");

    // the final result of an item is never followed at once by another
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result right after last");

    // acknowledgments carry no adjust offset
    a_ack_no_adj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == crt_pkg::KIND_ACK) |-> (o_adjust_offset_us == '0))
        else $error("ack with offset");

endmodule
